>>> hdl/assert_macros.svh
// Assertion macros, included by the positional list engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define PLE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PLE_ASSERT(lbl, clk, rstn, prop, msg)

`define PLE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> hdl/ple_pkg.sv
// Types and constants of the positional list engine.
`timescale 1ns / 1ps
`default_nettype none

package ple_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int CMD_W     = 3;
  localparam int STATUS_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_REM_LAST = 3'd1,
    CMD_CMP_REPL = 3'd2,
    CMD_READ     = 3'd3,
    CMD_REM_AT   = 3'd4,
    CMD_INSERT   = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_RANGE    = 3'd3,
    ST_MISMATCH = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_SHIFT,
    S_INSV,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

>>> hdl/positional_list_engine.sv
// Positional list engine: ordered list of signed words kept in one entry memory.
//
// Command channel in_*: in_tuser carries the command, in_tdata the position,
// the value and the expected value. Result channel out_*: out_tuser carries
// the status, out_tdata the read value and the element count after the command.
// Exactly one result transaction follows every command transaction, in order.
// Append, remove last, unused commands and failed checks go from idle straight
// to the response state; read and compare-replace pass a memory read state first.
// Remove at and insert pass a shift state (insert then writes the new value),
// unless the position is the last entry (remove) or count + 1 (insert).
// The shift moves one entry per cycle: one read and one write of the entry
// memory, whose read data is registered.
// One command is worked at a time; the next is taken as soon as the previous
// one has finished, even while its result still waits in the output register.
// When the receiver stalls, a finished result waits in a holding stage and the
// command channel stops taking transactions until the output register frees.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// memory contents are not cleared and no clearing pass runs.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module positional_list_engine
  import ple_pkg::*;
#(
  parameter  int DEPTH = DEPTH_DEF,
  localparam int PW    = $clog2(DEPTH + 1),
  localparam int AW    = $clog2(DEPTH),
  localparam int IN_W  = ((PW + 2 * DATA_W + 7) / 8) * 8,
  localparam int OUT_W = ((DATA_W + PW + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // position, value, expected, zero fill
  input  wire logic [IN_W-1:0]     in_tdata,
  // cmd
  input  wire logic [CMD_W-1:0]    in_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // read_value, count, zero fill
  output logic [OUT_W-1:0]         out_tdata,
  // status
  output logic [STATUS_W-1:0]      out_tuser
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] mem_rdata_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;

  state_t              state_r, state_nxt;
  logic [PW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       src_r, src_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic signed [DATA_W-1:0] exp_r, exp_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [DATA_W-1:0]   res_rd_r, res_rd_nxt;
  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_rd_r, out_rd_nxt;
  logic [PW-1:0]       out_count_r, out_count_nxt;

  logic                in_accept;
  cmd_t                cmd_in;
  logic [PW-1:0]       pos_in;
  logic signed [DATA_W-1:0] val_in;
  logic signed [DATA_W-1:0] exp_in;
  logic [PW-1:0]       pos_in_m1;
  logic [PW-1:0]       pos_r_m1;
  logic [PW-1:0]       cnt_m1;
  logic [PW-1:0]       cnt_p1;
  logic                full;
  logic                empty;
  logic                pos_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cmd_in    = cmd_t'(in_tuser);
  assign pos_in    = in_tdata[PW-1:0];
  assign val_in    = in_tdata[PW +: DATA_W];
  assign exp_in    = in_tdata[PW + DATA_W +: DATA_W];
  assign pos_in_m1 = pos_in - PW'(1);
  assign pos_r_m1  = pos_r - PW'(1);
  assign cnt_m1    = count_r - PW'(1);
  assign cnt_p1    = count_r + PW'(1);
  assign full      = (count_r >= PW'(DEPTH));
  assign empty     = (count_r == '0);
  assign pos_ok    = (pos_in != '0) && (pos_in <= count_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r        <= src_nxt;
    cmd_r        <= cmd_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    exp_r        <= exp_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    out_status_r <= out_status_nxt;
    out_rd_r     <= out_rd_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    src_nxt        = src_r;
    cmd_nxt        = cmd_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    exp_nxt        = exp_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_rd_nxt     = out_rd_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = mem_rdata_r;
    mem_re         = 1'b0;
    mem_ra         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          cmd_nxt        = cmd_in;
          pos_nxt        = pos_in;
          val_nxt        = val_in;
          exp_nxt        = exp_in;
          res_status_nxt = ST_OK;
          res_rd_nxt     = '0;
          state_nxt      = S_RESP;
          case (cmd_in)
            CMD_APPEND: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = count_r[AW-1:0];
                mem_wd    = val_in;
                count_nxt = cnt_p1;
              end
            end
            CMD_REM_LAST: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                count_nxt = cnt_m1;
              end
            end
            CMD_CMP_REPL, CMD_READ: begin
              if (!pos_ok) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = pos_in_m1[AW-1:0];
                state_nxt = S_RD;
              end
            end
            CMD_REM_AT: begin
              if (empty) begin
                res_status_nxt = ST_EMPTY;
              end else if (!pos_ok) begin
                res_status_nxt = ST_RANGE;
              end else if (pos_in == count_r) begin
                count_nxt = cnt_m1;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = pos_in[AW-1:0];
                src_nxt   = pos_in[AW-1:0];
                state_nxt = S_SHIFT;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end else if ((pos_in == '0) || (pos_in > cnt_p1)) begin
                res_status_nxt = ST_RANGE;
              end else if (pos_in == cnt_p1) begin
                mem_we    = 1'b1;
                mem_wa    = count_r[AW-1:0];
                mem_wd    = val_in;
                count_nxt = cnt_p1;
              end else begin
                mem_re    = 1'b1;
                mem_ra    = cnt_m1[AW-1:0];
                src_nxt   = cnt_m1[AW-1:0];
                state_nxt = S_SHIFT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_RESP;
        if (cmd_r == CMD_READ) begin
          res_rd_nxt = mem_rdata_r;
        end else if (mem_rdata_r != exp_r) begin
          res_status_nxt = ST_MISMATCH;
        end else begin
          mem_we = 1'b1;
          mem_wa = pos_r_m1[AW-1:0];
          mem_wd = val_r;
        end
      end
      S_SHIFT: begin
        mem_we = 1'b1;
        mem_wd = mem_rdata_r;
        if (cmd_r == CMD_REM_AT) begin
          mem_wa = src_r - AW'(1);
          if (src_r == cnt_m1[AW-1:0]) begin
            count_nxt = cnt_m1;
            state_nxt = S_RESP;
          end else begin
            mem_re  = 1'b1;
            mem_ra  = src_r + AW'(1);
            src_nxt = src_r + AW'(1);
          end
        end else begin
          mem_wa = src_r + AW'(1);
          if (src_r == pos_r_m1[AW-1:0]) begin
            state_nxt = S_INSV;
          end else begin
            mem_re  = 1'b1;
            mem_ra  = src_r - AW'(1);
            src_nxt = src_r - AW'(1);
          end
        end
      end
      S_INSV: begin
        mem_we    = 1'b1;
        mem_wa    = pos_r_m1[AW-1:0];
        mem_wd    = val_r;
        count_nxt = cnt_p1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_rd_nxt     = res_rd_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;

  always_comb begin
    out_tdata                 = '0;
    out_tdata[DATA_W-1:0]     = out_rd_r;
    out_tdata[DATA_W +: PW]   = out_count_r;
  end

  `PLE_ASSERT(a_count_bound, clk, rst_n, count_r <= PW'(DEPTH), "element count above depth")
  `PLE_ASSERT(a_shift_src, clk, rst_n, (state_r == S_SHIFT) |-> (src_r < count_r), "shift index beyond list")
  `PLE_ASSERT(a_count_change, clk, rst_n, (count_r != $past(count_r)) |-> (state_r == S_RESP), "count changed outside command completion")
  `PLE_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_r == S_IDLE) && !out_valid_r, "reset left engine busy")

endmodule

`default_nettype wire
